/* rtl/clm_pkg.sv */
// Shared types, constants and helpers for the cursor list manager.
// No dependencies; every other file imports this package.
package clm_pkg;

    // Store geometry
    localparam int ENTRIES   = 16;
    localparam int WORD_BITS = 64;
    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W     = $clog2(ENTRIES + 1);

    // Fixed field widths of the beats
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [IDX_W-1:0] NULL_IDX  = IDX_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 2'd0,
        CMD_INS_TAIL = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_READ     = 2'd3
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAIL,
        ST_DEL_RD,
        ST_DEL_CMP,
        ST_RD_RD,
        ST_RD_OUT,
        ST_EMIT
    } state_e;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  entry_value;
        logic [COUNT_W-1:0]  removed_count;
        logic [COUNT_W-1:0]  list_length;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  data;
    } link_wr_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] data;
    } word_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } word_rd_t;

    // Result of the shared walk/compare unit
    typedef struct packed {
        logic [IDX_W-1:0] nx;
        logic             nx_null;
        logic             match;
        logic             step_last;
        logic             step_end;
    } walk_t;

    // Any link at or above the null code counts as null
    function automatic logic [IDX_W-1:0] idx_clamp(input logic [IDX_W-1:0] x);
        return (x >= NULL_IDX) ? NULL_IDX : x;
    endfunction

endpackage

/* rtl/clm_node_store.sv */
// Node store: entry-word memory with registered read, and link flops.
// Depends on clm_pkg.
module clm_node_store import clm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  word_wr_t             word_wr,
    input  word_rd_t             word_rd,
    output logic [WORD_BITS-1:0] word_rdata,
    input  link_wr_t             link_wr_a,
    input  link_wr_t             link_wr_b,
    input  logic [IDX_W-1:0]     link_raddr,
    output logic [IDX_W-1:0]     link_rdata
);

    logic [WORD_BITS-1:0] word_mem [ENTRIES];
    logic [IDX_W-1:0]     link_reg [ENTRIES];

    always_ff @(posedge aclk) begin
        if (word_wr.en) begin
            word_mem[word_wr.addr] <= word_wr.data;
        end
        if (word_rd.en) begin
            word_rdata <= word_mem[word_rd.addr];
        end
    end

    // links reset to the initial free chain: i -> i-1, entry 0 null
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                link_reg[i] <= (i == 0) ? NULL_IDX : IDX_W'(i - 1);
            end
        end else begin
            if (link_wr_a.en) begin
                link_reg[link_wr_a.addr] <= link_wr_a.data;
            end
            if (link_wr_b.en) begin
                link_reg[link_wr_b.addr] <= link_wr_b.data;
            end
        end
    end

    assign link_rdata = (link_raddr >= NULL_IDX) ? NULL_IDX
                                                 : link_reg[link_raddr[ADDR_W-1:0]];

endmodule

/* rtl/clm_walk_unit.sv */
// Shared walk unit: link clamp, word equality compare and step-limit checks.
// Depends on clm_pkg.
module clm_walk_unit import clm_pkg::*; (
    input  logic [IDX_W-1:0]     link_rdata,
    input  logic [WORD_BITS-1:0] word_rdata,
    input  logic [WORD_BITS-1:0] key,
    input  logic [IDX_W-1:0]     steps,
    output walk_t                walk
);

    always_comb begin
        walk.nx        = idx_clamp(link_rdata);
        walk.nx_null   = (walk.nx == NULL_IDX);
        walk.match     = (word_rdata == key);
        walk.step_last = (steps == LAST_STEP);
        walk.step_end  = (steps == NULL_IDX);
    end

endmodule

/* rtl/clm_seq.sv */
// Command sequencer: list/free heads, entry count and the per-node walk.
// Depends on clm_pkg; drives clm_node_store and uses clm_walk_unit.
module clm_seq import clm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  in_item_t             s_data,
    output logic                 s_ready,
    input  logic                 slot_free,
    input  walk_t                walk,
    input  logic [WORD_BITS-1:0] word_rdata,
    output logic [WORD_BITS-1:0] key,
    output logic [IDX_W-1:0]     steps,
    output logic [IDX_W-1:0]     link_raddr,
    output link_wr_t             link_wr_a,
    output link_wr_t             link_wr_b,
    output word_wr_t             word_wr,
    output word_rd_t             word_rd,
    output logic                 res_push,
    output out_item_t            res
);

    state_e                state_reg,   state_next;
    logic [IDX_W-1:0]      head_reg,    head_next;
    logic [IDX_W-1:0]      free_reg,    free_next;
    logic [IDX_W-1:0]      count_reg,   count_next;
    logic [IDX_W-1:0]      cur_reg,     cur_next;
    logic [IDX_W-1:0]      prev_reg,    prev_next;
    logic [IDX_W-1:0]      steps_reg,   steps_next;
    logic [IDX_W-1:0]      removed_reg, removed_next;
    logic [ADDR_W-1:0]     new_reg,     new_next;
    logic [WORD_BITS-1:0]  key_reg,     key_next;
    logic [STATUS_W-1:0]   status_reg,  status_next;

    logic                  accept;
    logic [IDX_W-1:0]      head_c;
    logic [IDX_W-1:0]      count_inc;
    logic [IDX_W-1:0]      count_dec;
    logic [ADDR_W-1:0]     free_addr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign head_c    = idx_clamp(head_reg);
    assign count_inc = (count_reg < NULL_IDX) ? count_reg + IDX_W'(1) : count_reg;
    assign count_dec = (count_reg != '0) ? count_reg - IDX_W'(1) : count_reg;
    assign free_addr = free_reg[ADDR_W-1:0];
    assign key       = key_reg;
    assign steps     = steps_reg;
    // in idle the link port looks ahead along the free chain
    assign link_raddr = (state_reg == ST_IDLE) ? free_reg : cur_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd_e'(s_data.cmd))
                        CMD_INS_HEAD: state_next = ST_EMIT;
                        CMD_INS_TAIL: begin
                            if (free_reg == NULL_IDX || head_c == NULL_IDX
                                || head_c == free_reg) begin
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_TAIL;
                            end
                        end
                        CMD_DELETE:   state_next = ST_DEL_RD;
                        CMD_READ:     state_next = (head_c == NULL_IDX) ? ST_EMIT : ST_RD_RD;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TAIL: begin
                if (walk.nx_null || walk.nx[ADDR_W-1:0] == new_reg || walk.step_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_DEL_RD: begin
                state_next = (cur_reg == NULL_IDX || walk.step_end) ? ST_EMIT : ST_DEL_CMP;
            end
            ST_DEL_CMP: state_next = ST_DEL_RD;
            ST_RD_RD:   state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                if (slot_free) begin
                    state_next = (walk.nx_null || walk.step_last) ? ST_IDLE : ST_RD_RD;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls and register updates
    always_comb begin
        head_next    = head_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        steps_next   = steps_reg;
        removed_next = removed_reg;
        new_next     = new_reg;
        key_next     = key_reg;
        status_next  = status_reg;
        link_wr_a    = '0;
        link_wr_b    = '0;
        word_wr      = '0;
        word_rd      = '0;
        res_push     = 1'b0;
        res          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    removed_next = '0;
                    steps_next   = '0;
                    status_next  = STAT_OK;
                    key_next     = s_data.value[WORD_BITS-1:0];
                    unique case (cmd_e'(s_data.cmd))
                        CMD_INS_HEAD, CMD_INS_TAIL: begin
                            if (free_reg == NULL_IDX) begin
                                status_next = STAT_FULL;
                            end else begin
                                word_wr.en   = 1'b1;
                                word_wr.addr = free_addr;
                                word_wr.data = s_data.value[WORD_BITS-1:0];
                                free_next    = walk.nx;
                                new_next     = free_addr;
                                link_wr_a.en   = 1'b1;
                                link_wr_a.addr = free_addr;
                                if (cmd_e'(s_data.cmd) == CMD_INS_HEAD) begin
                                    link_wr_a.data = head_c;
                                    head_next      = free_reg;
                                    count_next     = count_inc;
                                end else begin
                                    link_wr_a.data = NULL_IDX;
                                    if (head_c == NULL_IDX || head_c == free_reg) begin
                                        head_next  = free_reg;
                                        count_next = count_inc;
                                    end else begin
                                        cur_next = head_c;
                                    end
                                end
                            end
                        end
                        CMD_DELETE: begin
                            prev_next = NULL_IDX;
                            cur_next  = head_c;
                        end
                        CMD_READ: begin
                            cur_next = head_c;
                            if (head_c == NULL_IDX) begin
                                status_next = STAT_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_TAIL: begin
                if (walk.nx_null || walk.nx[ADDR_W-1:0] == new_reg) begin
                    link_wr_a.en   = 1'b1;
                    link_wr_a.addr = cur_reg[ADDR_W-1:0];
                    link_wr_a.data = IDX_W'(new_reg);
                    count_next     = count_inc;
                end else if (walk.step_last) begin
                    // walk bound reached: the last node stepped to takes the link
                    link_wr_a.en   = 1'b1;
                    link_wr_a.addr = walk.nx[ADDR_W-1:0];
                    link_wr_a.data = IDX_W'(new_reg);
                    count_next     = count_inc;
                end else begin
                    cur_next   = walk.nx;
                    steps_next = steps_reg + IDX_W'(1);
                end
            end
            ST_DEL_RD: begin
                if (!(cur_reg == NULL_IDX || walk.step_end)) begin
                    word_rd.en   = 1'b1;
                    word_rd.addr = cur_reg[ADDR_W-1:0];
                end
            end
            ST_DEL_CMP: begin
                if (walk.match) begin
                    if (prev_reg == NULL_IDX) begin
                        head_next = walk.nx;
                    end else begin
                        link_wr_a.en   = 1'b1;
                        link_wr_a.addr = prev_reg[ADDR_W-1:0];
                        link_wr_a.data = walk.nx;
                    end
                    link_wr_b.en   = 1'b1;
                    link_wr_b.addr = cur_reg[ADDR_W-1:0];
                    link_wr_b.data = idx_clamp(free_reg);
                    free_next      = cur_reg;
                    removed_next   = removed_reg + IDX_W'(1);
                    count_next     = count_dec;
                end else begin
                    prev_next = cur_reg;
                end
                cur_next   = walk.nx;
                steps_next = steps_reg + IDX_W'(1);
            end
            ST_RD_RD: begin
                word_rd.en   = 1'b1;
                word_rd.addr = cur_reg[ADDR_W-1:0];
            end
            ST_RD_OUT: begin
                if (slot_free) begin
                    res_push          = 1'b1;
                    res.status        = STAT_OK;
                    res.entry_value   = VALUE_W'(word_rdata);
                    res.list_length   = COUNT_W'(count_reg);
                    res.last          = walk.nx_null || walk.step_last;
                    cur_next          = walk.nx;
                    steps_next        = steps_reg + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    res_push          = 1'b1;
                    res.status        = status_reg;
                    res.removed_count = COUNT_W'(removed_reg);
                    res.list_length   = COUNT_W'(count_reg);
                    res.last          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= NULL_IDX;
            free_reg  <= LAST_STEP;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        steps_reg   <= steps_next;
        removed_reg <= removed_next;
        new_reg     <= new_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
    end

    // entry count never runs past the store size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NULL_IDX)
        else $error("entry count out of range");

    // a result is only pushed into a free output slot
    a_push_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> slot_free)
        else $error("result pushed into occupied slot");

    // every compare step follows its word read
    a_cmp_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL_CMP) |-> ($past(state_reg) == ST_DEL_RD))
        else $error("compare without preceding read");

    // list and free chains never share a head node
    a_heads_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != NULL_IDX) |-> (head_reg != free_reg))
        else $error("list head equals free head");

endmodule

/* rtl/cursor_list_manager_core.sv */
// Top level of the cursor list manager: sequencer, walk unit, node store
// and the result output register. Depends on clm_pkg and all clm_* modules.
//
//  Channel | Ports                      | Payload    | Beats per command
//  --------+----------------------------+------------+-----------------------------
//  input   | s_valid, s_ready, s_data   | in_item_t  | 1
//  result  | m_valid, m_ready, m_data   | out_item_t | 1, or 1..ENTRIES on a read
//
//  Steps: head insert, full insert and empty read go straight to the result beat;
//  tail insert walks to the last node; delete reads, then compares each node; read
//  reads each node, then puts out its beat. The per-node steps are set by the
//  single link port and the registered read of the entry-word memory.
//  Reset: synchronous, active low; the link flops load the initial free chain
//  at once, so there is no clearing pass. Entry words are not reset.
//  Stalls: s_ready is high only while the sequencer is idle; a held result
//  beat in the output register stalls the sequencer, which keeps s_ready low.
module cursor_list_manager_core import clm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    walk_t                walk;
    link_wr_t             link_wr_a;
    link_wr_t             link_wr_b;
    word_wr_t             word_wr;
    word_rd_t             word_rd;
    logic [WORD_BITS-1:0] word_rdata;
    logic [WORD_BITS-1:0] key;
    logic [IDX_W-1:0]     steps;
    logic [IDX_W-1:0]     link_raddr;
    logic [IDX_W-1:0]     link_rdata;
    logic                 res_push;
    out_item_t            res;
    logic                 slot_free;

    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    // slot frees up in the same cycle the held beat is taken
    assign slot_free = !m_valid_reg || m_ready;

    clm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .s_ready    (s_ready),
        .slot_free  (slot_free),
        .walk       (walk),
        .word_rdata (word_rdata),
        .key        (key),
        .steps      (steps),
        .link_raddr (link_raddr),
        .link_wr_a  (link_wr_a),
        .link_wr_b  (link_wr_b),
        .word_wr    (word_wr),
        .word_rd    (word_rd),
        .res_push   (res_push),
        .res        (res)
    );

    clm_walk_unit u_walk (
        .link_rdata (link_rdata),
        .word_rdata (word_rdata),
        .key        (key),
        .steps      (steps),
        .walk       (walk)
    );

    clm_node_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_wr    (word_wr),
        .word_rd    (word_rd),
        .word_rdata (word_rdata),
        .link_wr_a  (link_wr_a),
        .link_wr_b  (link_wr_b),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata)
    );

    // result output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* dv/clm_list_checker.sv */
// Watches both channels of the cursor list manager, predicts each command's
// result beats and compares them field by field. Depends on clm_pkg only.
module clm_list_checker import clm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending,
    output int        beats_checked,
    output int        full_rejects,
    output int        nodes_removed
);

    // Private copy of the node store and list pointers
    logic [WORD_BITS-1:0] node_word [ENTRIES];
    logic [IDX_W-1:0]     node_link [ENTRIES];
    logic [IDX_W-1:0]     head_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [COUNT_W-1:0]   used_count;

    out_item_t awaited_beats [$];
    out_item_t want;
    bit        beat_bad;
    int        fails, checked, refused, deleted, n;

    // Successor of a node; anything at or above null reads as null
    function automatic logic [IDX_W-1:0] next_of(input logic [IDX_W-1:0] i);
        if (i >= NULL_IDX) return NULL_IDX;
        return (node_link[i[ADDR_W-1:0]] >= NULL_IDX) ? NULL_IDX : node_link[i[ADDR_W-1:0]];
    endfunction

    function automatic out_item_t reply(input status_e st, input logic [VALUE_W-1:0] w,
                                        input logic [COUNT_W-1:0] rm, input logic lst);
        out_item_t r;
        r.status        = st;
        r.entry_value   = w;
        r.removed_count = rm;
        r.list_length   = used_count;
        r.last          = lst;
        return r;
    endfunction

    task automatic apply_cmd(input in_item_t item);
        logic [IDX_W-1:0]     cur, prev, nx, slot;
        logic [WORD_BITS-1:0] word;
        logic [COUNT_W-1:0]   hits;
        int                   steps;
        word = item.value[WORD_BITS-1:0];
        hits = '0;
        case (cmd_e'(item.cmd))
            CMD_INS_HEAD, CMD_INS_TAIL: begin
                slot = free_idx;
                if (slot >= NULL_IDX) begin
                    awaited_beats.push_back(reply(STAT_FULL, '0, '0, 1'b1));
                    refused++;
                end else begin
                    free_idx = next_of(slot);
                    node_word[slot[ADDR_W-1:0]] = word;
                    if (item.cmd == CMD_INS_HEAD) begin
                        node_link[slot[ADDR_W-1:0]] = (head_idx >= NULL_IDX) ? NULL_IDX : head_idx;
                        head_idx = slot;
                    end else begin
                        node_link[slot[ADDR_W-1:0]] = NULL_IDX;
                        if (head_idx >= NULL_IDX || head_idx == slot) begin
                            head_idx = slot;
                        end else begin
                            cur = head_idx;
                            for (steps = 0; steps < ENTRIES; steps++) begin
                                nx = next_of(cur);
                                if (nx >= NULL_IDX || nx == slot) break;
                                cur = nx;
                            end
                            node_link[cur[ADDR_W-1:0]] = slot;
                        end
                    end
                    if (used_count < ENTRIES) used_count++;
                    awaited_beats.push_back(reply(STAT_OK, '0, '0, 1'b1));
                end
            end
            CMD_DELETE: begin
                prev = NULL_IDX;
                cur  = (head_idx >= NULL_IDX) ? NULL_IDX : head_idx;
                for (steps = 0; steps < ENTRIES && cur < NULL_IDX; steps++) begin
                    nx = next_of(cur);
                    if (node_word[cur[ADDR_W-1:0]] == word) begin
                        if (prev >= NULL_IDX) head_idx = nx;
                        else node_link[prev[ADDR_W-1:0]] = nx;
                        node_link[cur[ADDR_W-1:0]] = (free_idx >= NULL_IDX) ? NULL_IDX : free_idx;
                        free_idx = cur;
                        hits++;
                        if (used_count > 0) used_count--;
                    end else begin
                        prev = cur;
                    end
                    cur = nx;
                end
                deleted += hits;
                awaited_beats.push_back(reply(STAT_OK, '0, hits, 1'b1));
            end
            default: begin
                cur = (head_idx >= NULL_IDX) ? NULL_IDX : head_idx;
                if (cur >= NULL_IDX) begin
                    awaited_beats.push_back(reply(STAT_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (steps = 0; steps < ENTRIES && cur < NULL_IDX; steps++) begin
                        nx = next_of(cur);
                        awaited_beats.push_back(reply(STAT_OK,
                            VALUE_W'(node_word[cur[ADDR_W-1:0]]), '0,
                            (nx >= NULL_IDX) || (steps == ENTRIES - 1)));
                        cur = nx;
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            beat_bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (n = 0; n < ENTRIES; n++)
                node_link[n] = (n == 0) ? NULL_IDX : IDX_W'(n - 1);
            head_idx   = NULL_IDX;
            free_idx   = IDX_W'(ENTRIES - 1);
            used_count = '0;
            awaited_beats.delete();
        end else begin
            if (s_valid && s_ready) apply_cmd(s_data);
            if (m_valid && m_ready) begin
                if (awaited_beats.size() == 0) begin
                    $display("%0t: result beat with none expected, actual %p", $time, m_data);
                    fails++;
                end else begin
                    want     = awaited_beats.pop_front();
                    beat_bad = 1'b0;
                    check_field("status", VALUE_W'(want.status), VALUE_W'(m_data.status));
                    check_field("entry_value", want.entry_value, m_data.entry_value);
                    check_field("removed_count", VALUE_W'(want.removed_count),
                                VALUE_W'(m_data.removed_count));
                    check_field("list_length", VALUE_W'(want.list_length),
                                VALUE_W'(m_data.list_length));
                    check_field("last", VALUE_W'(want.last), VALUE_W'(m_data.last));
                    if (beat_bad) fails++;
                    checked++;
                end
            end
        end
        fail_count    <= fails;
        pending       <= awaited_beats.size();
        beats_checked <= checked;
        full_rejects  <= refused;
        nodes_removed <= deleted;
    end

endmodule

/* dv/tb_cursor_list_manager_core.sv */
// Stimulus and verdict for the cursor list manager core: directed list
// scenarios, then random command blocks. Depends on clm_pkg, the core, clm_list_checker.
module tb_cursor_list_manager_core;
    import clm_pkg::*;

    // Worst case is far below this: ~450 commands, reads of 16 beats each
    // waiting out receiver stalls, with sender gaps on top.
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_ITEMS = 420;
    localparam int BLOCK_LEN    = 20;
    localparam logic [VALUE_W-1:0] FILL_WORD = 64'h5555_5555_5555_5555;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int fail_count, pending, beats_checked, full_rejects, nodes_removed;
    int send_idle_pct;
    int recv_idle_pct = 66;
    int cycles;
    int items_sent;
    int fill_n;

    // Per-block pool of words, so that deletes actually find matches
    logic [VALUE_W-1:0] key_pool [8];
    int                 key_span;

    cursor_list_manager_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    clm_list_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .full_rejects  (full_rejects),
        .nodes_removed (nodes_removed)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still awaited", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [VALUE_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    // Valid is only dropped when a gap is wanted, so back-to-back beats
    // keep it high without a low/high pair in one step.
    task automatic send_cmd(input cmd_e c, input logic [VALUE_W-1:0] v);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{cmd: c, value: v};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold off the sender until every awaited beat has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Blocks alternate at random between growing the list (mostly inserts)
    // and shrinking it (mostly deletes), so it swings between empty and full.
    task automatic random_cmds(input int count);
        int               i, roll, k;
        bit               grow;
        cmd_e             c;
        logic [VALUE_W-1:0] v;
        for (i = 0; i < count; i++) begin
            if (i % BLOCK_LEN == 0) begin
                grow     = $urandom_range(1, 0);
                key_span = $urandom_range(8, 1);
                for (k = 0; k < 8; k++) key_pool[k] = rand_word();
            end
            roll = $urandom_range(99);
            if (grow) begin
                c = (roll < 35) ? CMD_INS_HEAD : (roll < 70) ? CMD_INS_TAIL :
                    (roll < 80) ? CMD_DELETE : CMD_READ;
            end else begin
                c = (roll < 15) ? CMD_INS_HEAD : (roll < 25) ? CMD_INS_TAIL :
                    (roll < 75) ? CMD_DELETE : CMD_READ;
            end
            // Mostly pool words; now and then a fresh word that matches nothing
            v = ($urandom_range(9) == 0) ? rand_word() : key_pool[$urandom_range(key_span - 1)];
            send_cmd(c, v);
        end
    endtask

    initial begin
        send_idle_pct = 6;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty list: read and delete both have nothing to walk
        send_cmd(CMD_READ, '0);
        send_cmd(CMD_DELETE, '1);
        // Tail insert into an empty list, then mixed ends with extreme words
        send_cmd(CMD_INS_TAIL, 64'h8000_0000_0000_0001);
        send_cmd(CMD_INS_HEAD, '1);
        send_cmd(CMD_INS_TAIL, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(CMD_INS_TAIL, '1);
        // All-ones sits at head and tail: one delete unlinks both ends
        send_cmd(CMD_DELETE, '1);
        // Delete that matches nothing
        send_cmd(CMD_DELETE, FILL_WORD);
        // Fill the store from both ends; tail inserts walk ever longer lists
        for (fill_n = 0; fill_n < ENTRIES - 2; fill_n++)
            send_cmd(fill_n[0] ? CMD_INS_TAIL : CMD_INS_HEAD, FILL_WORD);
        // Full store refuses either insert
        send_cmd(CMD_INS_HEAD, '1);
        send_cmd(CMD_INS_TAIL, '0);
        // Read of a full list: ENTRIES beats, last on the final one
        send_cmd(CMD_READ, '0);
        // Removes runs at both ends and nodes after surviving ones
        send_cmd(CMD_DELETE, FILL_WORD);
        drain();

        // Light sender gaps, heavy receiver stalls
        random_cmds(RANDOM_ITEMS / 3);
        drain();

        // Heavy sender gaps, light receiver stalls
        send_idle_pct = 66;
        recv_idle_pct <= 6;
        random_cmds(RANDOM_ITEMS / 3);
        drain();

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_cmds(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        // Room for any stray beat the core might still put out
        repeat (40) @(posedge aclk);

        $display("Sent %0d commands over three stall mixes; %0d result beats checked.",
                 items_sent, beats_checked);
        $display("Store-full refusals: %0d; nodes deleted: %0d.", full_rejects, nodes_removed);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
